/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent assertions of the pattern search checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define MBPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pattern search check failed");

// Next-cycle implication, off during reset.
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pattern search check failed");

// Next-cycle implication that also holds through reset.
`define MBPS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pattern search reset check failed");

`endif

/* src/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and helpers of the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;
  localparam int OFFSET_W    = 48;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int LANE_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_CARE    = 2'd1,
    REG_LENGTH  = 2'd2
  } cfg_reg_t;

  // Per-cell compare setup, picked by the top from the pattern registers.
  typedef struct packed {
    logic [BYTE_W-1:0] pat;
    logic [BYTE_W-1:0] care;
    logic              lane_on;
  } cell_cfg_t;

  // Raw length register value to (effective length - 1), clamped to 1..MAX.
  function automatic logic [LANE_W-1:0] len_to_m1(input logic [LEN_W-1:0] raw);
    logic [LANE_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (raw > LEN_W'(MAX_PATTERN)) begin
      res = LANE_W'(MAX_PATTERN - 1);
    end else begin
      res = LANE_W'(raw - 1'b1);
    end
    return res;
  endfunction

endpackage

/* src/masked_byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans a byte stream for a pattern of 1 to 8 bytes in which any nibble may
// be a wildcard (care mask nibble of zeros). One byte is taken per clock;
// the bytes run through a row of cells, each comparing its byte against the
// pattern byte for its position, so a hit is known in the cycle the last byte
// arrives and its result is in the output register in the cycle after that
// transfer. The input stalls only while a result sits in the output register
// and the output is stalled. A result carries the offset of the first matched
// byte (modulo 2^48) and the matched bytes in pattern order with unused bytes
// zero. Matches do not overlap: after a hit pattern_length new bytes are
// needed. Registers (index 0 pattern, 1 care mask, 2 length) are written by
// the user while idle, unenforced by the block; length 0 acts as 1, >8 as 8.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OFFSET_W-1:0]  out_match_offset,
  output logic [PAT_W-1:0]     out_matched_bytes,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  logic [PAT_W-1:0]    pattern_r;
  logic [PAT_W-1:0]    care_r;
  logic [LANE_W-1:0]   len_m1_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [OFFSET_W-1:0] offset_r;
  logic                out_valid_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [PAT_W-1:0]    out_bytes_r;

  logic                      in_acc;
  logic                      hit;
  logic [MAX_PATTERN-1:0]    eq;
  logic [BYTE_W-1:0]         new_byte [MAX_PATTERN];
  logic [BYTE_W-1:0]         byte_q   [MAX_PATTERN];
  cell_cfg_t                 ccfg     [MAX_PATTERN];
  logic [PAT_W-1:0]          match_w;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '1;
      len_m1_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN: pattern_r <= cfg_data;
        REG_CARE:    care_r    <= cfg_data;
        REG_LENGTH:  len_m1_r  <= len_to_m1(cfg_data[LEN_W-1:0]);
        default: ;
      endcase
    end
  end

  // cell row: cell a holds the byte of age a; it lines up with pattern byte
  // len-1-a
  genvar a;
  generate
    for (a = 0; a < MAX_PATTERN; a++) begin : g_cell
      logic [LANE_W-1:0] sel;

      if (a == 0) begin : g_head
        assign new_byte[a] = in_data_byte;
      end else begin : g_link
        assign new_byte[a] = byte_q[a-1];
      end

      assign sel             = len_m1_r - LANE_W'(a);
      assign ccfg[a].pat     = pattern_r[BYTE_W*sel +: BYTE_W];
      assign ccfg[a].care    = care_r[BYTE_W*sel +: BYTE_W];
      assign ccfg[a].lane_on = (LANE_W'(a) <= len_m1_r);

      mbps_cell u_cell (
        .clk     (clk),
        .adv     (in_acc),
        .byte_in (new_byte[a]),
        .ccfg    (ccfg[a]),
        .byte_q  (byte_q[a]),
        .eq      (eq[a])
      );
    end
  endgenerate

  assign fill_nxt = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;
  assign hit      = (&eq) && (fill_nxt > FILL_W'(len_m1_r));

  // window in pattern order, unused bytes zero
  always_comb begin
    logic [LANE_W-1:0] idx;
    match_w = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len_m1_r - LANE_W'(k);
      if (LANE_W'(k) <= len_m1_r) begin
        match_w[BYTE_W*k +: BYTE_W] = new_byte[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      offset_r <= '0;
    end else if (in_acc) begin
      fill_r   <= hit ? '0 : fill_nxt;
      offset_r <= offset_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hit) begin
      out_offset_r <= offset_r - OFFSET_W'(len_m1_r);
      out_bytes_r  <= match_w;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_offset  = out_offset_r;
  assign out_matched_bytes = out_bytes_r;

endmodule

/* src/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: holds a stream byte, passes it on to the next older cell
// on every transfer and compares the byte arriving from its neighbor (the input for the first cell).
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [BYTE_W-1:0] byte_in,
  input  cell_cfg_t         ccfg,
  output logic [BYTE_W-1:0] byte_q,
  output logic              eq
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  assign byte_nxt = adv ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

  // compare against the byte this cell takes on the transfer
  assign eq = !ccfg.lane_on || (((byte_in ^ ccfg.pat) & ccfg.care) == '0);

endmodule

/* src/mbps_checker.sv */
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern search, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbps_checker
  import mbps_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OFFSET_W-1:0]  out_match_offset,
  input logic [PAT_W-1:0]     out_matched_bytes
);

  logic [OFFSET_W+PAT_W-1:0] out_word;

  assign out_word = {out_match_offset, out_matched_bytes};

  // a stalled result stays put
  `MBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // the input only backs up behind a blocked result
  `MBPS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // every new result follows an input transfer
  `MBPS_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall))

  // reset empties the output register
  `MBPS_ASSERT_RST(a_reset_clear, !rst_n, !out_valid)

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);
